[design/line_sensor_position_estimator_macros.svh]
// Assertion macros for the line sensor position estimator.
// Used by modules that include this header; expects clk and rst_n in scope.
`ifndef LINE_SENSOR_POSITION_ESTIMATOR_MACROS_SVH
`define LINE_SENSOR_POSITION_ESTIMATOR_MACROS_SVH

// same-cycle implication
`define LSPE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lspe assertion failed");

// next-cycle implication
`define LSPE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lspe assertion failed");

`endif

[design/lspe_pkg.sv]
// Package for the line sensor position estimator: sizes, codes, types.
// No dependencies.
package lspe_pkg;

  localparam int SENSORS     = 8;
  localparam int MAX_SAMPLES = 128;
  localparam int SENS_W      = (SENSORS > 1) ? $clog2(SENSORS) : 1;

  localparam int DIV_STEPS   = 32;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [1:0] OP_CAL = 2'd0;
  localparam logic [1:0] OP_FIN = 2'd1;
  localparam logic [1:0] OP_POS = 2'd2;

  localparam logic [2:0] CFG_OUT_LOW     = 3'd0;
  localparam logic [2:0] CFG_OUT_HIGH    = 3'd1;
  localparam logic [2:0] CFG_SEEN_LEVEL  = 3'd2;
  localparam logic [2:0] CFG_SPLIT_LEVEL = 3'd3;
  localparam logic [2:0] CFG_PITCH       = 3'd4;

  localparam logic [11:0] RST_OUT_LOW     = 12'd0;
  localparam logic [11:0] RST_OUT_HIGH    = 12'd2000;
  localparam logic [11:0] RST_SEEN_LEVEL  = 12'd1000;
  localparam logic [11:0] RST_SPLIT_LEVEL = 12'd2048;
  localparam logic [11:0] RST_PITCH       = 12'd1000;

  localparam logic [15:0] POS_NONE = 16'hFFFF;
  localparam logic [15:0] POS_MAX  = 16'h7FFF;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP,
    S_MSTART,
    S_MWAIT,
    S_LVL,
    S_WMUL,
    S_ACC,
    S_PSTART,
    S_PWAIT,
    S_EMIT,
    S_FSTART,
    S_FWAIT,
    S_FCLR
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

[design/lspe_div.sv]
// Shared radix-2 restoring divider, 32-bit dividend by 16-bit divisor.
// Depends on lspe_pkg.
module lspe_div (
  input  logic               clk,
  input  logic               rst_n,
  input  lspe_pkg::div_req_t req,
  output lspe_pkg::div_rsp_t rsp
);
  import lspe_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [31:0]          quo_r;
  logic [15:0]          rem_r;
  logic [15:0]          dvs_r;

  logic [16:0] rem_sh;
  logic [16:0] rem_dif;
  logic        ge;

  assign rem_sh  = {rem_r, quo_r[31]};
  assign rem_dif = rem_sh - {1'b0, dvs_r};
  assign ge      = (rem_sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[30:0], ge};
        rem_r <= ge ? rem_dif[15:0] : rem_sh[15:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

[design/line_sensor_position_estimator.sv]
// Line position estimator for a reflectance sensor array: calibration
// accumulators, per-sample level mapping and frame weighted average.
// Depends on lspe_pkg, lspe_div and line_sensor_position_estimator_macros.svh.
//
// A calibration sample (op 0) is accumulated on transfer. A position
// sample (op 2) is mapped through a division, skipped when its sensor's
// calibration pair is equal. The sample that closes a frame then runs the
// frame average division before the result is offered, skipped when the
// level sum is zero. A finish command (op 1) divides each sensor's low and
// high sums by their counts, skipping each empty side. All divisions use
// the single 32-step radix-2 divider, shared by the level mapping, the
// frame average and the calibration averages. in_tready is high only while
// the sequencer is idle; a pending result waits in the output register and
// does not block new input until another result must be written over it.
module line_sensor_position_estimator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [1:0] op, [4:2] sensor, [16:5] sample, rest zero
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] position, [16] line_lost, [19:17] last_seen
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [11:0] cfg_wdata
);
  import lspe_pkg::*;

  `include "line_sensor_position_estimator_macros.svh"

  state_t state_r, state_nxt;

  logic [11:0] out_low_r, out_high_r, seen_level_r, split_level_r, pitch_r;

  logic [19:0] low_sum_r  [SENSORS];
  logic [19:0] high_sum_r [SENSORS];
  logic [7:0]  low_cnt_r  [SENSORS];
  logic [7:0]  high_cnt_r [SENSORS];
  logic [11:0] cal_low_r  [SENSORS];
  logic [11:0] cal_high_r [SENSORS];

  logic [2:0]        sensor_r;
  logic [SENS_W-1:0] idx_r;
  logic [11:0]       sample_r;
  logic              last_r;

  logic signed [25:0] prod_r;
  logic signed [12:0] den_r;
  logic               neg_r;
  logic signed [26:0] mapped_r;
  logic [11:0]        lvl_r;
  logic [14:0]        wt_r;
  logic [26:0]        wprod_r;

  logic [31:0] wsum_r;
  logic [15:0] lsum_r;
  logic        frame_seen_r;
  logic [2:0]  seen_idx_r;
  logic [15:0] pos_r;

  logic [SENS_W-1:0] fin_idx_r;
  logic              fin_side_r;

  logic        out_valid_r;
  logic [19:0] out_data_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic        in_xfer;
  logic [1:0]  in_op;
  logic [2:0]  in_sensor;
  logic [11:0] in_sample;
  logic              in_valid_sensor;
  logic [SENS_W-1:0] in_idx;

  assign in_op     = in_tdata[1:0];
  assign in_sensor = in_tdata[4:2];
  assign in_sample = in_tdata[16:5];
  assign in_idx    = in_sensor[SENS_W-1:0];
  assign in_valid_sensor = ({1'b0, in_sensor} < 4'(SENSORS));
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // mapping stage operands
  logic signed [12:0] raw_off, span;
  logic [11:0]        cal_lo_s, cal_hi_s;
  assign cal_lo_s = cal_low_r[idx_r];
  assign cal_hi_s = cal_high_r[idx_r];
  assign raw_off  = $signed({1'b0, sample_r}) - $signed({1'b0, cal_lo_s});
  assign span     = $signed({1'b0, out_high_r}) - $signed({1'b0, out_low_r});

  logic [25:0] prod_mag;
  logic [12:0] den_mag;
  assign prod_mag = prod_r[25] ? 26'(-prod_r) : 26'(prod_r);
  assign den_mag  = den_r[12] ? 13'(-den_r) : 13'(den_r);

  logic signed [26:0] q_signed;
  assign q_signed = neg_r ? -$signed({2'b00, div_rsp.quotient[24:0]})
                          : $signed({2'b00, div_rsp.quotient[24:0]});

  logic signed [27:0] lvl_v;
  logic signed [27:0] tmin_x, tmax_x;
  logic [11:0]        lvl_clamp;
  assign tmin_x = $signed({16'd0, out_low_r});
  assign tmax_x = $signed({16'd0, out_high_r});
  assign lvl_v  = tmax_x - 28'(mapped_r);
  always_comb begin
    priority if (lvl_v < tmin_x) begin
      lvl_clamp = out_low_r;
    end else if (lvl_v > tmax_x) begin
      lvl_clamp = out_high_r;
    end else begin
      lvl_clamp = lvl_v[11:0];
    end
  end

  logic [32:0] wsum_add;
  logic [16:0] lsum_add;
  assign wsum_add = {1'b0, wsum_r} + {6'd0, wprod_r};
  assign lsum_add = {1'b0, lsum_r} + {5'd0, lvl_r};

  logic [7:0]  fin_cnt;
  logic [19:0] fin_sum;
  logic        fin_end;
  assign fin_cnt = fin_side_r ? high_cnt_r[fin_idx_r] : low_cnt_r[fin_idx_r];
  assign fin_sum = fin_side_r ? high_sum_r[fin_idx_r] : low_sum_r[fin_idx_r];
  assign fin_end = fin_side_r && (fin_idx_r == SENS_W'(SENSORS - 1));

  logic emit_ok;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_op == OP_FIN) begin
            state_nxt = S_FSTART;
          end else if (in_op == OP_POS) begin
            if (in_valid_sensor) begin
              state_nxt = S_MAP;
            end else if (in_tlast) begin
              state_nxt = S_PSTART;
            end
          end
        end
      end
      S_MAP:    state_nxt = S_MSTART;
      S_MSTART: state_nxt = (den_r == 13'sd0) ? S_LVL : S_MWAIT;
      S_MWAIT:  state_nxt = div_rsp.done ? S_LVL : S_MWAIT;
      S_LVL:    state_nxt = S_WMUL;
      S_WMUL:   state_nxt = S_ACC;
      S_ACC:    state_nxt = last_r ? S_PSTART : S_IDLE;
      S_PSTART: state_nxt = (lsum_r == 16'd0) ? S_EMIT : S_PWAIT;
      S_PWAIT:  state_nxt = div_rsp.done ? S_EMIT : S_PWAIT;
      S_EMIT:   state_nxt = emit_ok ? S_IDLE : S_EMIT;
      S_FSTART: begin
        if (fin_cnt == 8'd0) begin
          state_nxt = fin_end ? S_FCLR : S_FSTART;
        end else begin
          state_nxt = S_FWAIT;
        end
      end
      S_FWAIT: begin
        if (div_rsp.done) begin
          state_nxt = fin_end ? S_FCLR : S_FSTART;
        end
      end
      S_FCLR:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    div_req = '0;
    emit_ok = 1'b0;
    unique case (state_r)
      S_MSTART: begin
        div_req.start    = (den_r != 13'sd0);
        div_req.dividend = {6'd0, prod_mag};
        div_req.divisor  = {3'd0, den_mag};
      end
      S_PSTART: begin
        div_req.start    = (lsum_r != 16'd0);
        div_req.dividend = wsum_r;
        div_req.divisor  = lsum_r;
      end
      S_FSTART: begin
        div_req.start    = (fin_cnt != 8'd0);
        div_req.dividend = {12'd0, fin_sum};
        div_req.divisor  = {8'd0, fin_cnt};
      end
      S_EMIT: begin
        emit_ok = !out_valid_r || out_tready;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  lspe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_low_r     <= RST_OUT_LOW;
      out_high_r    <= RST_OUT_HIGH;
      seen_level_r  <= RST_SEEN_LEVEL;
      split_level_r <= RST_SPLIT_LEVEL;
      pitch_r       <= RST_PITCH;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_OUT_LOW:     out_low_r     <= cfg_wdata;
        CFG_OUT_HIGH:    out_high_r    <= cfg_wdata;
        CFG_SEEN_LEVEL:  seen_level_r  <= cfg_wdata;
        CFG_SPLIT_LEVEL: split_level_r <= cfg_wdata;
        CFG_PITCH:       pitch_r       <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSORS; i++) begin
        low_sum_r[i]  <= '0;
        high_sum_r[i] <= '0;
        low_cnt_r[i]  <= '0;
        high_cnt_r[i] <= '0;
        cal_low_r[i]  <= '0;
        cal_high_r[i] <= '0;
      end
      wsum_r       <= '0;
      lsum_r       <= '0;
      frame_seen_r <= 1'b0;
      seen_idx_r   <= '0;
      fin_idx_r    <= '0;
      fin_side_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && !emit_ok) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            sensor_r   <= in_sensor;
            idx_r      <= in_idx;
            sample_r   <= in_sample;
            last_r     <= in_tlast;
            fin_idx_r  <= '0;
            fin_side_r <= 1'b0;
            if (in_op == OP_CAL && in_valid_sensor) begin
              if (in_sample < split_level_r) begin
                if (low_cnt_r[in_idx] < 8'(MAX_SAMPLES)) begin
                  low_sum_r[in_idx] <= low_sum_r[in_idx] + {8'd0, in_sample};
                  low_cnt_r[in_idx] <= low_cnt_r[in_idx] + 8'd1;
                end
              end else begin
                if (high_cnt_r[in_idx] < 8'(MAX_SAMPLES)) begin
                  high_sum_r[in_idx] <= high_sum_r[in_idx] + {8'd0, in_sample};
                  high_cnt_r[in_idx] <= high_cnt_r[in_idx] + 8'd1;
                end
              end
            end
          end
        end
        S_MAP: begin
          prod_r <= raw_off * span;
          den_r  <= $signed({1'b0, cal_hi_s}) - $signed({1'b0, cal_lo_s});
        end
        S_MSTART: begin
          neg_r <= prod_r[25] ^ den_r[12];
          if (den_r == 13'sd0) begin
            mapped_r <= $signed({15'd0, out_low_r});
          end
        end
        S_MWAIT: begin
          if (div_rsp.done) begin
            mapped_r <= q_signed + $signed({15'd0, out_low_r});
          end
        end
        S_LVL: begin
          lvl_r <= lvl_clamp;
          wt_r  <= sensor_r * pitch_r;
        end
        S_WMUL: begin
          wprod_r <= lvl_r * wt_r;
        end
        S_ACC: begin
          wsum_r <= wsum_add[32] ? 32'hFFFF_FFFF : wsum_add[31:0];
          lsum_r <= lsum_add[16] ? 16'hFFFF : lsum_add[15:0];
          if (lvl_r >= seen_level_r) begin
            frame_seen_r <= 1'b1;
            seen_idx_r   <= sensor_r;
          end
        end
        S_PSTART: begin
          if (lsum_r == 16'd0) begin
            pos_r <= POS_NONE;
          end
        end
        S_PWAIT: begin
          if (div_rsp.done) begin
            pos_r <= (div_rsp.quotient > 32'(POS_MAX)) ? POS_MAX
                                                       : div_rsp.quotient[15:0];
          end
        end
        S_EMIT: begin
          if (emit_ok) begin
            out_valid_r  <= 1'b1;
            out_data_r   <= {seen_idx_r, !frame_seen_r, pos_r};
            wsum_r       <= '0;
            lsum_r       <= '0;
            frame_seen_r <= 1'b0;
          end
        end
        S_FSTART: begin
          if (fin_cnt == 8'd0) begin
            if (fin_side_r) begin
              cal_high_r[fin_idx_r] <= '0;
              fin_idx_r <= fin_idx_r + 1'b1;
            end else begin
              cal_low_r[fin_idx_r] <= '0;
            end
            fin_side_r <= !fin_side_r;
          end
        end
        S_FWAIT: begin
          if (div_rsp.done) begin
            if (fin_side_r) begin
              cal_high_r[fin_idx_r] <= div_rsp.quotient[11:0];
              fin_idx_r <= fin_idx_r + 1'b1;
            end else begin
              cal_low_r[fin_idx_r] <= div_rsp.quotient[11:0];
            end
            fin_side_r <= !fin_side_r;
          end
        end
        S_FCLR: begin
          for (int i = 0; i < SENSORS; i++) begin
            low_sum_r[i]  <= '0;
            high_sum_r[i] <= '0;
            low_cnt_r[i]  <= '0;
            high_cnt_r[i] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_data_r};

  `LSPE_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy)
  `LSPE_ASSERT_IMP(a_lvl_in_range, state_r == S_WMUL && out_low_r <= out_high_r,
                   lvl_r >= out_low_r && lvl_r <= out_high_r)
  `LSPE_ASSERT_NXT(a_frame_cleared, emit_ok,
                   lsum_r == 16'd0 && wsum_r == 32'd0 && !frame_seen_r && out_valid_r)
  `LSPE_ASSERT_NXT(a_fin_clears, state_r == S_FCLR,
                   low_cnt_r[0] == 8'd0 && high_cnt_r[0] == 8'd0 && state_r == S_IDLE)

endmodule
